>>> design/sorted_id_offset_table_top_assert.svh
// Assertion macros for the sorted id/offset table.
`ifndef SORTED_ID_OFFSET_TABLE_TOP_ASSERT_SVH
`define SORTED_ID_OFFSET_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SIOT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SIOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SIOT_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SIOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> design/siot_pkg.sv
// ----------------------------------------------------------------------------
// siot_pkg
// Shared types and codes for the sorted id/offset table.
// ----------------------------------------------------------------------------
`default_nettype none
package siot_pkg;
   localparam int unsigned WORD_W = 64;
   localparam int unsigned DCNT_W = 16;
   localparam int unsigned STAT_W = 4;

   typedef enum logic [1:0] {
      OP_LOAD     = 2'd0,
      OP_RESOLVE  = 2'd1,
      OP_IDENTIFY = 2'd2,
      OP_ADDRESS  = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_NONE          = 4'd0,
      ST_NOT_LOADED    = 4'd1,
      ST_EMPTY         = 4'd2,
      ST_SIZE_MISMATCH = 4'd3,
      ST_UNSORTED      = 4'd4,
      ST_OUT_OF_IMAGE  = 4'd5,
      ST_UNKNOWN       = 4'd6,
      ST_NULL_BASE     = 4'd7,
      ST_CAPACITY      = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      REG_IMAGE_SIZE = 2'd0,
      REG_IMAGE_BASE = 2'd1,
      REG_DECL_COUNT = 2'd2
   } reg_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch the request
      logic load;      // run load checks and write
      logic start;     // reset search bounds
      logic rd;        // issue memory read at probe index
      logic step;      // update bounds from read data
      logic scan_rd;   // issue scan read
      logic scan_step; // test scan data, advance
      logic finish;    // form result from search state
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic search_done;
      logic scan_done;
      logic scan_hit;
   } sts_type;
endpackage
`default_nettype wire

>>> design/sorted_id_offset_table_top.sv
// Resolve and address results come from a binary search on the table memories, one read
// per step; identify scans the entries in order, one memory read and compare per entry,
// stopping at the first match.
// One request in flight; the next is taken the cycle after the result is handed off.
// Reset (synchronous, active high) empties the table and clears control and config
// registers; data registers and memories need no clearing pass.
// ----------------------------------------------------------------------------
// sorted_id_offset_table_top
// Id/offset table with streamed load, binary-search resolve and offset scan.
// ----------------------------------------------------------------------------
`default_nettype none
module sorted_id_offset_table_top #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request: tuser = {last_entry, first_entry} from bit 0 up: first_entry, last_entry
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // tdata from bit 0: opcode[1:0], key_id[65:2], entry_offset[129:66], zero pad to 136
   input  wire logic [135:0]  req_tdata,
   input  wire logic [1:0]    req_tuser,
   // response tdata from bit 0: status[3:0], result_value[67:4],
   // entry_count[78:68], pad to 80
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [79:0]        rsp_tdata,
   // response tuser: loaded
   output logic               rsp_tuser,
   // configuration write
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [63:0]   csr_data
);
   import siot_pkg::*;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

   cmd_type           cmd;
   sts_type           sts;
   logic              busy, req_fire, rsp_fire;
   logic [WORD_W-1:0] size_ff, base_ff;
   logic [DCNT_W-1:0] dcnt_ff;
   status_type        st;
   logic [WORD_W-1:0] val;
   logic [CW-1:0]     cnt;

   assign req_tready = !busy;
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign csr_ready  = 1'b1;

   // hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0; base_ff <= '0; dcnt_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_IMAGE_SIZE: size_ff <= csr_data;
            REG_IMAGE_BASE: base_ff <= csr_data;
            REG_DECL_COUNT: dcnt_ff <= csr_data[DCNT_W-1:0];
            default: ;
         endcase
      end
   end

   siot_ctrl u_ctrl (
      .clock, .reset, .req_fire, .req_op(op_type'(req_tdata[1:0])), .sts,
      .rsp_fire, .cmd, .busy, .rsp_valid(rsp_tvalid)
   );

   siot_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
      .clock, .reset, .cmd, .sts,
      .req_op(op_type'(req_tdata[1:0])), .req_first(req_tuser[0]), .req_last(req_tuser[1]),
      .req_key(req_tdata[65:2]), .req_off(req_tdata[129:66]),
      .image_size(size_ff), .image_base(base_ff), .decl_count(dcnt_ff),
      .out_status(st), .out_value(val), .out_count(cnt)
   );

   assign rsp_tdata = {1'b0, 11'(cnt), val, 4'(st)};
   assign rsp_tuser = (cnt != '0);
endmodule
`default_nettype wire

>>> design/siot_ctrl.sv
// ----------------------------------------------------------------------------
// siot_ctrl
// Sequencer for load, binary search and linear scan.
// ----------------------------------------------------------------------------
`default_nettype none
module siot_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_fire,
   input  wire siot_pkg::op_type  req_op,
   input  wire siot_pkg::sts_type sts,
   input  wire logic              rsp_fire,
   output siot_pkg::cmd_type      cmd,
   output logic                   busy,
   output logic                   rsp_valid
);
   import siot_pkg::*;
   `include "sorted_id_offset_table_top_assert.svh"

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_SRD, S_SSTEP, S_CRD, S_CSTEP, S_FIN, S_OUT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.capture = 1'b1;
               if (req_op == OP_LOAD) state_in = S_LOAD;
               else if (req_op == OP_IDENTIFY) state_in = S_CRD;
               else state_in = S_SRD;
               if (req_op != OP_LOAD && req_op != OP_IDENTIFY) cmd.start = 1'b1;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_OUT;
         end
         S_SRD: begin
            // once the bounds meet the probe sits on the final index: read it
            cmd.rd = 1'b1;
            if (sts.search_done) state_in = S_FIN;
            else state_in = S_SSTEP;
         end
         S_SSTEP: begin
            cmd.step = 1'b1;
            state_in = S_SRD;
         end
         S_CRD: begin
            if (sts.scan_done) state_in = S_FIN;
            else begin
               cmd.scan_rd = 1'b1;
               state_in = S_CSTEP;
            end
         end
         S_CSTEP: begin
            cmd.scan_step = 1'b1;
            state_in = sts.scan_hit ? S_FIN : S_CRD;
         end
         S_FIN: begin
            // result formed from the read data registered by the final read
            cmd.finish = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_fire) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);

   `SIOT_ASSERT_IMPL(a_fire_idle, clock, reset, req_fire, state_ff == S_IDLE, "request while busy")
   `SIOT_ASSERT_NEXT(a_load_out, clock, reset, state_ff == S_LOAD, state_ff == S_OUT, "load stuck")
   `SIOT_ASSERT_NEXT(a_hold_out, clock, reset, rsp_valid && !rsp_fire, rsp_valid, "result dropped")
endmodule
`default_nettype wire

>>> design/siot_dp.sv
// ----------------------------------------------------------------------------
// siot_dp
// Table memories, load checks, search bounds and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module siot_dp #(
   parameter int unsigned TABLE_DEPTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire siot_pkg::cmd_type          cmd,
   output siot_pkg::sts_type               sts,
   input  wire siot_pkg::op_type           req_op,
   input  wire logic                       req_first,
   input  wire logic                       req_last,
   input  wire logic [siot_pkg::WORD_W-1:0] req_key,
   input  wire logic [siot_pkg::WORD_W-1:0] req_off,
   input  wire logic [siot_pkg::WORD_W-1:0] image_size,
   input  wire logic [siot_pkg::WORD_W-1:0] image_base,
   input  wire logic [siot_pkg::DCNT_W-1:0] decl_count,
   output siot_pkg::status_type            out_status,
   output logic [siot_pkg::WORD_W-1:0]     out_value,
   output logic [$clog2(TABLE_DEPTH+1)-1:0] out_count
);
   import siot_pkg::*;
   localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned AW = $clog2(TABLE_DEPTH);
   localparam logic [CW:0] DEPTH_C = (CW + 1)'(TABLE_DEPTH);

   logic [WORD_W-1:0] id_mem  [TABLE_DEPTH];
   logic [WORD_W-1:0] off_mem [TABLE_DEPTH];
   logic [WORD_W-1:0] id_rd_ff, off_rd_ff;

   op_type            op_ff;
   logic              first_ff, last_ff;
   logic [WORD_W-1:0] key_ff, qoff_ff, prev_ff;
   logic [CW-1:0]     comm_ff, lidx_ff, lo_ff, hi_ff, probe;
   logic              active_ff;
   status_type        stat_ff;
   logic [WORD_W-1:0] val_ff;

   // load decision
   logic              wr_en;
   status_type        ld_stat;
   logic              ld_abort, ld_commit;
   logic [CW:0]       dcnt_x, idx_x;

   // query result
   status_type        fin_stat;
   logic [WORD_W-1:0] fin_val;

   always_comb begin
      dcnt_x = (CW + 1)'(decl_count);
      if (DCNT_W > CW + 1) dcnt_x = (decl_count > DCNT_W'(TABLE_DEPTH)) ? DEPTH_C + 1'b1
                                    : (CW + 1)'(decl_count);
      idx_x = first_ff ? '0 : {1'b0, lidx_ff};
      wr_en = 1'b0; ld_abort = 1'b0; ld_commit = 1'b0; ld_stat = ST_NONE;
      if (first_ff && decl_count == '0) begin
         ld_abort = 1'b1; ld_stat = ST_EMPTY;
      end else if (!first_ff && !active_ff) begin
         ld_stat = ST_NOT_LOADED;
      end else if (dcnt_x > DEPTH_C) begin
         ld_abort = 1'b1; ld_stat = ST_CAPACITY;
      end else if (idx_x >= dcnt_x) begin
         ld_abort = 1'b1; ld_stat = ST_SIZE_MISMATCH;
      end else if (idx_x != '0 && key_ff <= prev_ff) begin
         ld_abort = 1'b1; ld_stat = ST_UNSORTED;
      end else if (image_size != '0 && qoff_ff >= image_size) begin
         ld_abort = 1'b1; ld_stat = ST_OUT_OF_IMAGE;
      end else begin
         wr_en = 1'b1;
         if (last_ff) begin
            if (idx_x + 1'b1 != dcnt_x) begin
               ld_abort = 1'b1; ld_stat = ST_SIZE_MISMATCH;
            end else ld_commit = 1'b1;
         end
      end
   end

   always_comb begin
      fin_stat = ST_UNKNOWN;
      fin_val  = '0;
      if (op_ff == OP_ADDRESS && image_base == '0) fin_stat = ST_NULL_BASE;
      else if (comm_ff == '0) fin_stat = ST_NOT_LOADED;
      else if (op_ff == OP_IDENTIFY) begin
         if (lo_ff < comm_ff && off_rd_ff == qoff_ff) begin
            fin_stat = ST_NONE; fin_val = id_rd_ff;
         end
      end else if (lo_ff < comm_ff && id_rd_ff == key_ff) begin
         fin_stat = ST_NONE;
         fin_val  = (op_ff == OP_ADDRESS) ? off_rd_ff + image_base : off_rd_ff;
      end
   end

   assign probe = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign sts.search_done = (lo_ff >= hi_ff);
   assign sts.scan_done   = (lo_ff >= comm_ff);
   assign sts.scan_hit    = (off_rd_ff == qoff_ff);

   always_ff @(posedge clock) begin
      if (cmd.load && wr_en) begin
         id_mem[idx_x[AW-1:0]]  <= key_ff;
         off_mem[idx_x[AW-1:0]] <= qoff_ff;
      end
      if (cmd.rd || cmd.scan_rd) begin
         id_rd_ff  <= id_mem[cmd.rd ? probe[AW-1:0] : lo_ff[AW-1:0]];
         off_rd_ff <= off_mem[cmd.rd ? probe[AW-1:0] : lo_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comm_ff <= '0; lidx_ff <= '0; active_ff <= 1'b0; prev_ff <= '0;
      end else if (cmd.load) begin
         if (ld_abort) begin
            comm_ff <= '0; lidx_ff <= '0; active_ff <= 1'b0;
         end else if (ld_commit) begin
            comm_ff <= idx_x[CW-1:0] + 1'b1; lidx_ff <= '0; active_ff <= 1'b0;
         end else if (wr_en) begin
            // table stays empty while a load is open
            comm_ff <= '0; active_ff <= 1'b1;
            lidx_ff <= idx_x[CW-1:0] + 1'b1;
         end
         if (wr_en) prev_ff <= key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op; first_ff <= req_first; last_ff <= req_last;
         key_ff <= req_key; qoff_ff <= req_off;
      end
      if (cmd.start || cmd.capture) begin
         lo_ff <= '0;
         hi_ff <= comm_ff;
      end else if (cmd.step) begin
         if (id_rd_ff < key_ff) lo_ff <= probe + 1'b1;
         else hi_ff <= probe;
      end else if (cmd.scan_step && !sts.scan_hit) lo_ff <= lo_ff + 1'b1;
      if (cmd.load) begin
         stat_ff <= ld_stat; val_ff <= '0;
      end else if (cmd.finish) begin
         stat_ff <= fin_stat; val_ff <= fin_val;
      end
   end

   assign out_status = stat_ff;
   assign out_value  = val_ff;
   assign out_count  = comm_ff;
endmodule
`default_nettype wire
